// ===== hw/rtl/pic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pic_pkg;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd2;
  localparam logic [2:0] REG_DRIVE_MIN     = 3'd3;
  localparam logic [2:0] REG_DRIVE_MAX     = 3'd4;
  localparam logic [31:0] DRIVE_MAX_RESET  = 32'h00FF_0000;

  // Program steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_ERR  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_KP   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_KTSE = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SUM  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_PSUM = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DRV  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_AW   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_OUT  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_CLR  = 4'd8;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_KI_TS,
    MUL_KP_ERR,
    MUL_KTS_ERR
  } mul_sel_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_ERR,
    ALU_KTS,
    ALU_PROP,
    ALU_SUM,
    ALU_PSUM,
    ALU_DRV,
    ALU_AW,
    ALU_CLR
  } alu_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_IF_CLR,
    JMP_ALWAYS
  } jmp_t;

  typedef struct packed {
    mul_sel_t          mul;
    alu_op_t           alu;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              done;
  } ctrl_word_t;

  typedef struct packed {
    logic [15:0]        prop_gain;
    logic [15:0]        integ_gain;
    logic [15:0]        sample_period;
    logic signed [31:0] drive_min;
    logic signed [31:0] drive_max;
  } cfg_t;

  localparam ctrl_word_t UOP_NOP = '{MUL_NONE, ALU_NOP, JMP_NEXT, STEP_ERR, 1'b0};

  // Microcode ROM
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = UOP_NOP;
    unique case (step)
      STEP_ERR:  w = '{MUL_KI_TS,   ALU_ERR,  JMP_IF_CLR, STEP_CLR, 1'b0};
      STEP_KP:   w = '{MUL_KP_ERR,  ALU_KTS,  JMP_NEXT,   STEP_ERR, 1'b0};
      STEP_KTSE: w = '{MUL_KTS_ERR, ALU_PROP, JMP_NEXT,   STEP_ERR, 1'b0};
      STEP_SUM:  w = '{MUL_NONE,    ALU_SUM,  JMP_NEXT,   STEP_ERR, 1'b0};
      STEP_PSUM: w = '{MUL_NONE,    ALU_PSUM, JMP_NEXT,   STEP_ERR, 1'b0};
      STEP_DRV:  w = '{MUL_NONE,    ALU_DRV,  JMP_NEXT,   STEP_ERR, 1'b0};
      STEP_AW:   w = '{MUL_NONE,    ALU_AW,   JMP_NEXT,   STEP_ERR, 1'b0};
      STEP_OUT:  w = '{MUL_NONE,    ALU_NOP,  JMP_NEXT,   STEP_ERR, 1'b1};
      STEP_CLR:  w = '{MUL_NONE,    ALU_CLR,  JMP_ALWAYS, STEP_OUT, 1'b0};
      default:   w = UOP_NOP;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pic_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pic_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target;
  logic signed [15:0] measured;
  logic               clear_integral;

  modport source (output valid, target, measured, clear_integral, input ready);
  modport sink   (input valid, target, measured, clear_integral, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pic_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pic_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic signed [31:0] integral_value;

  modport source (output valid, drive, integral_value, input ready);
  modport sink   (input valid, drive, integral_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pic_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pic_sequencer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               clr,
  input  wire logic               out_stall,
  output logic                    busy,
  output pic_pkg::ctrl_word_t     uop
);
  import pic_pkg::*;

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  ctrl_word_t        rom_word;
  logic              hold;

  assign rom_word = ucode(step_r);
  // the output step waits while the result register is full and not taken
  assign hold = rom_word.done && out_stall;
  assign uop  = (busy_r && !hold) ? rom_word : UOP_NOP;
  assign busy = busy_r;

  // step counter with conditional jumps
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        step_nxt = STEP_ERR;
      end
    end else if (!hold) begin
      if (rom_word.done) begin
        busy_nxt = 1'b0;
      end else begin
        unique case (rom_word.jmp)
          JMP_IF_CLR: step_nxt = clr ? rom_word.target : step_r + 1'b1;
          JMP_ALWAYS: step_nxt = rom_word.target;
          default:    step_nxt = step_r + 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_ERR;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/pic_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pic_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic signed [15:0] target,
  input  wire logic signed [15:0] measured,
  input  wire logic               clear_integral,
  input  wire pic_pkg::cfg_t      cfg,
  input  wire pic_pkg::ctrl_word_t uop,
  output logic                    clr,
  output logic signed [31:0]      drive,
  output logic signed [31:0]      integ
);
  import pic_pkg::*;

  localparam logic signed [35:0] MAX32 = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] MIN32 = -36'sh0_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > MAX32) r = MAX32[31:0];
    else if (v < MIN32) r = MIN32[31:0];
    return r;
  endfunction

  logic signed [15:0] tgt_r, meas_r;
  logic               clr_r;
  logic signed [16:0] err_r;
  logic signed [50:0] prod_r;
  logic [31:0]        kts_r;
  logic signed [33:0] prop_r;
  logic signed [31:0] sum_r;
  logic signed [34:0] tot_r, lo_r, hi_r;
  logic signed [31:0] drive_r;
  logic signed [31:0] acc_r;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [35:0] sum_wide;
  logic signed [34:0] sum_ext, prop_ext, min_ext, max_ext, aw_val;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uop.mul)
      MUL_KI_TS: begin
        mul_a = {17'd0, cfg.integ_gain};
        mul_b = {2'd0, cfg.sample_period};
      end
      MUL_KP_ERR: begin
        mul_a = {17'd0, cfg.prop_gain};
        mul_b = {err_r[16], err_r};
      end
      MUL_KTS_ERR: begin
        mul_a = {1'b0, kts_r};
        mul_b = {err_r[16], err_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // increment is the product floored by 16 bits
  assign sum_wide = {{1{acc_r[31]}}, {4{acc_r[31]}}, acc_r[30:0]}
                    + {prod_r[50], prod_r[50:16]};
  assign sum_ext  = {{3{sum_r[31]}}, sum_r};
  assign prop_ext = {prop_r[33], prop_r};
  assign min_ext  = {{3{cfg.drive_min[31]}}, cfg.drive_min};
  assign max_ext  = {{3{cfg.drive_max[31]}}, cfg.drive_max};

  // anti-windup clamp, lower bound tested first
  always_comb begin
    aw_val = sum_ext;
    if (sum_ext < lo_r) aw_val = lo_r;
    else if (sum_ext > hi_r) aw_val = hi_r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tgt_r  <= target;
      meas_r <= measured;
      clr_r  <= clear_integral;
    end
    if (uop.mul != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
    unique case (uop.alu)
      ALU_ERR:  err_r  <= {tgt_r[15], tgt_r} - {meas_r[15], meas_r};
      ALU_KTS:  kts_r  <= prod_r[31:0];
      ALU_PROP: prop_r <= prod_r[33:0];
      ALU_SUM:  sum_r  <= sat32(sum_wide);
      ALU_PSUM: begin
        tot_r <= prop_ext + sum_ext;
        lo_r  <= min_ext - prop_ext;
      end
      ALU_DRV: begin
        if (tot_r < min_ext) drive_r <= cfg.drive_min;
        else if (tot_r > max_ext) drive_r <= cfg.drive_max;
        else drive_r <= tot_r[31:0];
        hi_r <= max_ext - prop_ext;
      end
      ALU_CLR:  drive_r <= '0;
      default:  ;
    endcase
  end

  // kept integral state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (uop.alu == ALU_AW) begin
      acc_r <= sat32({aw_val[34], aw_val});
    end else if (uop.alu == ALU_CLR) begin
      acc_r <= '0;
    end
  end

  assign clr   = clr_r;
  assign drive = drive_r;
  assign integ = acc_r;
endmodule
`default_nettype wire

// ===== hw/rtl/pi_controller_anti_windup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// PI controller with integral clamping anti-windup, one item at a time.
// Each item runs through a microprogram around one shared 33x18 multiplier;
// a clear item jumps from the error step to the clear step and then to the
// output step. The next item is taken the cycle after the result is written
// to the output register.
// Reset (rst_n low, synchronous): integral, registers to defaults, no result.
module pi_controller_anti_windup (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  pic_in_if.sink                    in_ch,
  pic_out_if.source                 out_ch,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [pic_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import pic_pkg::*;

  cfg_t               cfg_r;
  logic               busy;
  logic               accept;
  logic               out_stall;
  logic               clr;
  ctrl_word_t         uop;
  logic signed [31:0] dp_drive, dp_integ;
  logic               out_valid_r;
  logic signed [31:0] out_drive_r, out_integ_r;
  logic [2:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= '0;
      cfg_r.integ_gain    <= '0;
      cfg_r.sample_period <= '0;
      cfg_r.drive_min     <= '0;
      cfg_r.drive_max     <= DRIVE_MAX_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_PROP_GAIN:     cfg_r.prop_gain     <= pwdata[15:0];
        REG_INTEG_GAIN:    cfg_r.integ_gain    <= pwdata[15:0];
        REG_SAMPLE_PERIOD: cfg_r.sample_period <= pwdata[15:0];
        REG_DRIVE_MIN:     cfg_r.drive_min     <= pwdata;
        REG_DRIVE_MAX:     cfg_r.drive_max     <= pwdata;
        default:           ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_PROP_GAIN:     prdata = {16'd0, cfg_r.prop_gain};
      REG_INTEG_GAIN:    prdata = {16'd0, cfg_r.integ_gain};
      REG_SAMPLE_PERIOD: prdata = {16'd0, cfg_r.sample_period};
      REG_DRIVE_MIN:     prdata = cfg_r.drive_min;
      REG_DRIVE_MAX:     prdata = cfg_r.drive_max;
      default:           prdata = '0;
    endcase
  end

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && !busy;
  assign out_stall   = out_valid_r && !out_ch.ready;

  pic_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .clr       (clr),
    .out_stall (out_stall),
    .busy      (busy),
    .uop       (uop)
  );

  pic_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .target         (in_ch.target),
    .measured       (in_ch.measured),
    .clear_integral (in_ch.clear_integral),
    .cfg            (cfg_r),
    .uop            (uop),
    .clr            (clr),
    .drive          (dp_drive),
    .integ          (dp_integ)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uop.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uop.done) begin
      out_drive_r <= dp_drive;
      out_integ_r <= dp_integ;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.drive          = out_drive_r;
  assign out_ch.integral_value = out_integ_r;
endmodule
`default_nettype wire

// ===== hw/rtl/pic_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pic_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_drive,
  input wire logic [31:0] out_integ,
  input wire logic        pready
);
  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // after reset: no result pending and input open
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("state not cleared by reset");

  // one item at a time: busy right after accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken while item in progress");

  // accept is never directly followed by a rising result
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid))
    else $error("result appeared too early");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_integ))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");
endmodule

bind pi_controller_anti_windup pic_checker u_pic_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_drive (out_ch.drive),
  .out_integ (out_ch.integral_value),
  .pready    (pready)
);
`default_nettype wire
